// ===== rtl/bific_pkg.sv =====
// Package: shared constants and codes for the banked IRQ/FIQ interrupt controller.
`timescale 1ns / 1ps
`default_nettype none

package bific_pkg;

    // Default sizing
    localparam int NUM_BANKS_DEF = 4;
    localparam int NUM_LINES_DEF = 128;

    // Line number split: low bits pick the bit, high bits pick the bank
    localparam int BANK_SHIFT    = 5;
    localparam int LINE_BIT_MASK = 'h1F;
    localparam int BANK_BITS     = 32;

    // Item kinds (code 3 means nothing and changes nothing)
    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Register selects
    typedef enum logic [3:0] {
        REG_CPU_IRQ_ACT = 4'd0,
        REG_COP_IRQ_ACT = 4'd1,
        REG_CPU_FIQ_ACT = 4'd2,
        REG_COP_FIQ_ACT = 4'd3,
        REG_LINE_STATUS = 4'd4,
        REG_FORCED      = 4'd5,
        REG_CPU_ENABLE  = 4'd6,
        REG_CPU_CLASS   = 4'd7,
        REG_COP_ENABLE  = 4'd8,
        REG_COP_CLASS   = 4'd9,
        REG_FIR_SET     = 4'd10,
        REG_FIR_CLR     = 4'd11,
        REG_CPU_EN_SET  = 4'd12,
        REG_CPU_EN_CLR  = 4'd13,
        REG_COP_EN_SET  = 4'd14,
        REG_COP_EN_CLR  = 4'd15
    } reg_sel_t;

endpackage

`default_nettype wire

// ===== rtl/banked_irq_fiq_interrupt_controller_top.sv =====
// Top level: banked IRQ/FIQ interrupt controller with two targets.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | in        | in_valid / in_ready  | kind, line, level, bank, reg_sel, write_data
//  out     | out       | out_valid / out_ready| read_data, cpu_irq, cpu_fiq, cop_irq,
//          |           |                      | cop_fiq, cpu_pending, cop_pending
//
//  One item per cycle unless a held result stalls; its result shows in the next cycle.
//  The bank state and the result register are updated in the same edge, so
//  the result register is the only stage between the two channels.
//  rst_n clears all bank state and the result valid flag.
//  in_ready drops only while a result is held and out_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module banked_irq_fiq_interrupt_controller_top
    import bific_pkg::*;
#(
    parameter int NUM_BANKS = NUM_BANKS_DEF,
    parameter int NUM_LINES = NUM_LINES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [6:0]  line,
    input  wire logic        level,
    input  wire logic [1:0]  bank,
    input  wire logic [3:0]  reg_sel,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      read_data,
    output logic             cpu_irq,
    output logic             cpu_fiq,
    output logic             cop_irq,
    output logic             cop_fiq,
    output logic             cpu_pending,
    output logic             cop_pending
);

    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    typedef logic [BANK_BITS-1:0] word_t;

    // Bank state
    word_t line_status_reg [NUM_BANKS];
    word_t forced_reg      [NUM_BANKS];
    word_t cpu_enable_reg  [NUM_BANKS];
    word_t cpu_class_reg   [NUM_BANKS];
    word_t cop_enable_reg  [NUM_BANKS];
    word_t cop_class_reg   [NUM_BANKS];

    word_t line_status_next [NUM_BANKS];
    word_t forced_next      [NUM_BANKS];
    word_t cpu_enable_next  [NUM_BANKS];
    word_t cpu_class_next   [NUM_BANKS];
    word_t cop_enable_next  [NUM_BANKS];
    word_t cop_class_next   [NUM_BANKS];

    // Result register
    logic        out_valid_reg;
    logic [31:0] read_data_reg;
    logic        cpu_irq_reg;
    logic        cpu_fiq_reg;
    logic        cop_irq_reg;
    logic        cop_fiq_reg;

    logic [31:0] read_data_next;
    logic        cpu_irq_next;
    logic        cpu_fiq_next;
    logic        cop_irq_next;
    logic        cop_fiq_next;

    logic              take;
    logic [1:0]        line_bank;
    logic [BANK_W-1:0] sel_bank;
    logic              line_ok;
    logic              bank_ok;
    logic [4:0]        bit_idx;
    word_t             line_mask;
    reg_sel_t          sel_code;
    word_t             src;
    word_t             cpu_src;
    word_t             cop_src;
    word_t             cur_src;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Address decode: one bank is touched per item
    assign line_bank = line[6:BANK_SHIFT];
    assign line_ok   = (int'(line) < NUM_LINES) && (int'(line_bank) < NUM_BANKS);
    assign bank_ok   = int'(bank) < NUM_BANKS;
    assign sel_bank  = (kind == KIND_LINE) ? BANK_W'(line_bank) : BANK_W'(bank);
    assign bit_idx   = 5'(line & 7'(LINE_BIT_MASK));
    assign line_mask = word_t'(1) << bit_idx;
    assign sel_code  = reg_sel_t'(reg_sel);

    // Next bank state and register read
    always_comb
    begin
        cur_src        = forced_reg[sel_bank] | line_status_reg[sel_bank];
        read_data_next = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            line_status_next[b] = line_status_reg[b];
            forced_next[b]      = forced_reg[b];
            cpu_enable_next[b]  = cpu_enable_reg[b];
            cpu_class_next[b]   = cpu_class_reg[b];
            cop_enable_next[b]  = cop_enable_reg[b];
            cop_class_next[b]   = cop_class_reg[b];
        end

        case (kind)
            KIND_LINE:
            begin
                if (line_ok)
                begin
                    if (level)
                        line_status_next[sel_bank] = line_status_reg[sel_bank] | line_mask;
                    else
                        line_status_next[sel_bank] = line_status_reg[sel_bank] & ~line_mask;
                end
            end
            KIND_READ:
            begin
                if (bank_ok)
                begin
                    unique case (sel_code) inside
                        REG_CPU_IRQ_ACT:
                            read_data_next = cur_src & cpu_enable_reg[sel_bank]
                                             & ~cpu_class_reg[sel_bank];
                        REG_COP_IRQ_ACT:
                            read_data_next = cur_src & cop_enable_reg[sel_bank]
                                             & ~cop_class_reg[sel_bank];
                        REG_CPU_FIQ_ACT:
                            read_data_next = cur_src & cpu_enable_reg[sel_bank]
                                             & cpu_class_reg[sel_bank];
                        REG_COP_FIQ_ACT:
                            read_data_next = cur_src & cop_enable_reg[sel_bank]
                                             & cop_class_reg[sel_bank];
                        REG_LINE_STATUS: read_data_next = line_status_reg[sel_bank];
                        REG_FORCED:      read_data_next = forced_reg[sel_bank];
                        REG_CPU_ENABLE:  read_data_next = cpu_enable_reg[sel_bank];
                        REG_CPU_CLASS:   read_data_next = cpu_class_reg[sel_bank];
                        REG_COP_ENABLE:  read_data_next = cop_enable_reg[sel_bank];
                        REG_COP_CLASS:   read_data_next = cop_class_reg[sel_bank];
                        REG_FIR_SET, REG_FIR_CLR, REG_CPU_EN_SET, REG_CPU_EN_CLR,
                        REG_COP_EN_SET, REG_COP_EN_CLR:
                            read_data_next = '0;
                        default:         read_data_next = '0;
                    endcase
                end
            end
            KIND_WRITE:
            begin
                if (bank_ok)
                begin
                    unique case (sel_code) inside
                        REG_CPU_CLASS:  cpu_class_next[sel_bank] = write_data;
                        REG_COP_CLASS:  cop_class_next[sel_bank] = write_data;
                        REG_FIR_SET:    forced_next[sel_bank] = forced_reg[sel_bank] | write_data;
                        REG_FIR_CLR:    forced_next[sel_bank] = forced_reg[sel_bank] & ~write_data;
                        REG_CPU_EN_SET:
                            cpu_enable_next[sel_bank] = cpu_enable_reg[sel_bank] | write_data;
                        REG_CPU_EN_CLR:
                            cpu_enable_next[sel_bank] = cpu_enable_reg[sel_bank] & ~write_data;
                        REG_COP_EN_SET:
                            cop_enable_next[sel_bank] = cop_enable_reg[sel_bank] | write_data;
                        REG_COP_EN_CLR:
                            cop_enable_next[sel_bank] = cop_enable_reg[sel_bank] & ~write_data;
                        REG_CPU_IRQ_ACT, REG_COP_IRQ_ACT, REG_CPU_FIQ_ACT, REG_COP_FIQ_ACT,
                        REG_LINE_STATUS, REG_FORCED, REG_CPU_ENABLE, REG_COP_ENABLE:
                            ;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Output levels from the state after the item: OR of active words over banks
    always_comb
    begin
        cpu_irq_next = 1'b0;
        cpu_fiq_next = 1'b0;
        cop_irq_next = 1'b0;
        cop_fiq_next = 1'b0;
        src          = '0;
        cpu_src      = '0;
        cop_src      = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            src          = forced_next[b] | line_status_next[b];
            cpu_src      = src & cpu_enable_next[b];
            cop_src      = src & cop_enable_next[b];
            cpu_irq_next = cpu_irq_next | (|(cpu_src & ~cpu_class_next[b]));
            cpu_fiq_next = cpu_fiq_next | (|(cpu_src & cpu_class_next[b]));
            cop_irq_next = cop_irq_next | (|(cop_src & ~cop_class_next[b]));
            cop_fiq_next = cop_fiq_next | (|(cop_src & cop_class_next[b]));
        end
    end

    // Bank state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                line_status_reg[b] <= '0;
                forced_reg[b]      <= '0;
                cpu_enable_reg[b]  <= '0;
                cpu_class_reg[b]   <= '0;
                cop_enable_reg[b]  <= '0;
                cop_class_reg[b]   <= '0;
            end
        end
        else if (take)
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                line_status_reg[b] <= line_status_next[b];
                forced_reg[b]      <= forced_next[b];
                cpu_enable_reg[b]  <= cpu_enable_next[b];
                cpu_class_reg[b]   <= cpu_class_next[b];
                cop_enable_reg[b]  <= cop_enable_next[b];
                cop_class_reg[b]   <= cop_class_next[b];
            end
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            read_data_reg <= read_data_next;
            cpu_irq_reg   <= cpu_irq_next;
            cpu_fiq_reg   <= cpu_fiq_next;
            cop_irq_reg   <= cop_irq_next;
            cop_fiq_reg   <= cop_fiq_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign cpu_irq     = cpu_irq_reg;
    assign cpu_fiq     = cpu_fiq_reg;
    assign cop_irq     = cop_irq_reg;
    assign cop_fiq     = cop_fiq_reg;
    assign cpu_pending = cpu_irq_reg | cpu_fiq_reg;
    assign cop_pending = cop_irq_reg | cop_fiq_reg;

endmodule

`default_nettype wire

// ===== rtl/bific_checker.sv =====
// Checker: port-level properties of the interrupt controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bific_checker
    import bific_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  kind,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] read_data,
    input wire logic        cpu_irq,
    input wire logic        cpu_fiq,
    input wire logic        cop_irq,
    input wire logic        cop_fiq,
    input wire logic        cpu_pending,
    input wire logic        cop_pending
);

    // A held result stays until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("result dropped or changed while stalled");

    // Every input transfer yields a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("input transfer produced no result");

    // With no result held the input side is open
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // Pending flags follow the class levels
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cpu_pending == (cpu_irq || cpu_fiq))
                   && (cop_pending == (cop_irq || cop_fiq)))
        else $error("pending flag disagrees with IRQ/FIQ levels");

    // Only reads return data
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind != KIND_READ |=> read_data == 32'd0)
        else $error("non-read item returned read data");

endmodule

bind banked_irq_fiq_interrupt_controller_top bific_checker u_bific_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the banked IRQ/FIQ interrupt controller: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb_top
    import bific_pkg::*;
;

    localparam logic [1:0] KIND_NONE      = 2'd3;
    localparam int         ITEMS_PER_PHASE = 363;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         MAX_REPORTS     = 10;

    // One input item and one result, as seen on the ports
    typedef struct {
        logic [1:0]  kind;
        logic [6:0]  line;
        logic        level;
        logic [1:0]  bank;
        reg_sel_t    sel;
        logic [31:0] wdata;
    } irq_item_t;

    typedef struct {
        logic [31:0] read_data;
        logic        cpu_irq;
        logic        cpu_fiq;
        logic        cop_irq;
        logic        cop_fiq;
        logic        cpu_pending;
        logic        cop_pending;
    } irq_result_t;

    // Shadow of the controller state plus the queue of expected results
    class irq_scoreboard;
        bit [31:0]   status_w  [NUM_BANKS_DEF];
        bit [31:0]   forced_w  [NUM_BANKS_DEF];
        bit [31:0]   cpu_en_w  [NUM_BANKS_DEF];
        bit [31:0]   cpu_cls_w [NUM_BANKS_DEF];
        bit [31:0]   cop_en_w  [NUM_BANKS_DEF];
        bit [31:0]   cop_cls_w [NUM_BANKS_DEF];
        irq_result_t expected_q[$];
        int          mismatches;

        function new();
            foreach (status_w[b])
            begin
                status_w[b]  = '0;
                forced_w[b]  = '0;
                cpu_en_w[b]  = '0;
                cpu_cls_w[b] = '0;
                cop_en_w[b]  = '0;
                cop_cls_w[b] = '0;
            end
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Register view of one bank; active words follow from the current state
        function bit [31:0] read_word(int b, reg_sel_t sel);
            bit [31:0] src;
            src = status_w[b] | forced_w[b];
            case (sel)
                REG_CPU_IRQ_ACT: return src & cpu_en_w[b] & ~cpu_cls_w[b];
                REG_COP_IRQ_ACT: return src & cop_en_w[b] & ~cop_cls_w[b];
                REG_CPU_FIQ_ACT: return src & cpu_en_w[b] & cpu_cls_w[b];
                REG_COP_FIQ_ACT: return src & cop_en_w[b] & cop_cls_w[b];
                REG_LINE_STATUS: return status_w[b];
                REG_FORCED:      return forced_w[b];
                REG_CPU_ENABLE:  return cpu_en_w[b];
                REG_CPU_CLASS:   return cpu_cls_w[b];
                REG_COP_ENABLE:  return cop_en_w[b];
                REG_COP_CLASS:   return cop_cls_w[b];
                default:         return '0;
            endcase
        endfunction

        // Apply an accepted input transfer and queue the result it should produce
        function void note_item(irq_item_t it);
            irq_result_t r;
            int          b;
            bit [31:0]   bit_mask;
            r = '{read_data: '0, cpu_irq: 1'b0, cpu_fiq: 1'b0, cop_irq: 1'b0,
                  cop_fiq: 1'b0, cpu_pending: 1'b0, cop_pending: 1'b0};
            case (it.kind)
                KIND_LINE:
                begin
                    b        = int'(it.line >> BANK_SHIFT);
                    bit_mask = 32'd1 << (it.line & LINE_BIT_MASK);
                    if (b < NUM_BANKS_DEF)
                    begin
                        if (it.level)
                            status_w[b] |= bit_mask;
                        else
                            status_w[b] &= ~bit_mask;
                    end
                end
                KIND_READ:
                begin
                    if (it.bank < NUM_BANKS_DEF)
                        r.read_data = read_word(int'(it.bank), it.sel);
                end
                KIND_WRITE:
                begin
                    b = int'(it.bank);
                    if (b < NUM_BANKS_DEF)
                    begin
                        case (it.sel)
                            REG_CPU_CLASS:  cpu_cls_w[b] = it.wdata;
                            REG_COP_CLASS:  cop_cls_w[b] = it.wdata;
                            REG_FIR_SET:    forced_w[b] |= it.wdata;
                            REG_FIR_CLR:    forced_w[b] &= ~it.wdata;
                            REG_CPU_EN_SET: cpu_en_w[b] |= it.wdata;
                            REG_CPU_EN_CLR: cpu_en_w[b] &= ~it.wdata;
                            REG_COP_EN_SET: cop_en_w[b] |= it.wdata;
                            REG_COP_EN_CLR: cop_en_w[b] &= ~it.wdata;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
            // Output levels are the OR over all banks
            for (int i = 0; i < NUM_BANKS_DEF; i++)
            begin
                r.cpu_irq |= |read_word(i, REG_CPU_IRQ_ACT);
                r.cpu_fiq |= |read_word(i, REG_CPU_FIQ_ACT);
                r.cop_irq |= |read_word(i, REG_COP_IRQ_ACT);
                r.cop_fiq |= |read_word(i, REG_COP_FIQ_ACT);
            end
            r.cpu_pending = r.cpu_irq | r.cpu_fiq;
            r.cop_pending = r.cop_irq | r.cop_fiq;
            expected_q.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
        endfunction

        function void cmp(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
                flag(what, want, got);
        endfunction

        // Compare an accepted output transfer with the oldest expectation
        function void check_result(irq_result_t got);
            irq_result_t want;
            if (expected_q.size() == 0)
            begin
                flag("unexpected result", '0, got.read_data);
                return;
            end
            want = expected_q.pop_front();
            cmp("read_data",   want.read_data,          got.read_data);
            cmp("cpu_irq",     32'(want.cpu_irq),       32'(got.cpu_irq));
            cmp("cpu_fiq",     32'(want.cpu_fiq),       32'(got.cpu_fiq));
            cmp("cop_irq",     32'(want.cop_irq),       32'(got.cop_irq));
            cmp("cop_fiq",     32'(want.cop_fiq),       32'(got.cop_fiq));
            cmp("cpu_pending", 32'(want.cpu_pending),   32'(got.cpu_pending));
            cmp("cop_pending", 32'(want.cop_pending),   32'(got.cop_pending));
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  kind       = '0;
    logic [6:0]  line       = '0;
    logic        level      = 1'b0;
    logic [1:0]  bank       = '0;
    logic [3:0]  reg_sel    = '0;
    logic [31:0] write_data = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] read_data;
    logic        cpu_irq;
    logic        cpu_fiq;
    logic        cop_irq;
    logic        cop_fiq;
    logic        cpu_pending;
    logic        cop_pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    irq_scoreboard sb = new();

    banked_irq_fiq_interrupt_controller_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .line        (line),
        .level       (level),
        .bank        (bank),
        .reg_sel     (reg_sel),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .cpu_irq     (cpu_irq),
        .cpu_fiq     (cpu_fiq),
        .cop_irq     (cop_irq),
        .cop_fiq     (cop_fiq),
        .cpu_pending (cpu_pending),
        .cop_pending (cop_pending)
    );

    // 100 MHz clock
    always #5 clk = ~clk;

    // Receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Transfer monitor: values are sampled as they stood before the edge
    always @(posedge clk)
    begin
        irq_item_t   it;
        irq_result_t res;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                res.read_data   = read_data;
                res.cpu_irq     = cpu_irq;
                res.cpu_fiq     = cpu_fiq;
                res.cop_irq     = cop_irq;
                res.cop_fiq     = cop_fiq;
                res.cpu_pending = cpu_pending;
                res.cop_pending = cop_pending;
                sb.check_result(res);
            end
            if (in_valid && in_ready)
            begin
                it.kind  = kind;
                it.line  = line;
                it.level = level;
                it.bank  = bank;
                it.sel   = reg_sel_t'(reg_sel);
                it.wdata = write_data;
                sb.note_item(it);
            end
        end
    end

    function automatic irq_item_t mk_item(logic [1:0] k, logic [6:0] ln, logic lv,
                                          logic [1:0] bk, reg_sel_t sel, logic [31:0] d);
        irq_item_t it;
        it.kind  = k;
        it.line  = ln;
        it.level = lv;
        it.bank  = bk;
        it.sel   = sel;
        it.wdata = d;
        return it;
    endfunction

    // Mix of dense, sparse and extreme words so output levels toggle both ways
    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'd1 << $urandom_range(31);
            2:       return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic irq_item_t rand_item();
        irq_item_t it;
        int        pick;
        it = mk_item(2'($urandom_range(3)), 7'($urandom_range(127)), 1'($urandom_range(1)),
                     2'($urandom_range(3)), reg_sel_t'($urandom_range(15)), rand_word());
        pick = $urandom_range(99);
        if (pick < 35)
            it.kind = KIND_LINE;
        else if (pick < 60)
            it.kind = KIND_READ;
        else if (pick < 96)
        begin
            it.kind = KIND_WRITE;
            // mostly writable selects, now and then a read-only one
            if ($urandom_range(9) != 0)
                it.sel = reg_sel_t'($urandom_range(15, 7));
        end
        else
            it.kind = KIND_NONE;
        return it;
    endfunction

    // Present one item and hold it until the transfer happens
    task automatic send_item(irq_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= it.kind;
        line       <= it.line;
        level      <= it.level;
        bank       <= it.bank;
        reg_sel    <= it.sel;
        write_data <= it.wdata;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Run watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("banked_irq_fiq_interrupt_controller_top regression: fail");
        $finish;
    end

    // Main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: line extremes, every write select, ignored cases, reads
        send_item(mk_item(KIND_LINE,  7'd0,   1'b1, 2'd0, REG_CPU_IRQ_ACT, '0));
        send_item(mk_item(KIND_LINE,  7'd127, 1'b1, 2'd0, REG_CPU_IRQ_ACT, '0));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd0, REG_CPU_EN_SET, 32'hFFFF_FFFF));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd3, REG_COP_EN_SET, 32'hFFFF_FFFF));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd0, REG_CPU_CLASS,  32'h0000_0001));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd3, REG_COP_CLASS,  32'h8000_0000));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd1, REG_FIR_SET,    32'h8000_0001));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd1, REG_CPU_EN_SET, 32'h0000_0001));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd1, REG_CPU_ENABLE, 32'hFFFF_FFFF));
        send_item(mk_item(KIND_NONE,  7'd127, 1'b1, 2'd3, REG_COP_EN_CLR, 32'hFFFF_FFFF));
        for (int s = 0; s <= 10; s++)
            send_item(mk_item(KIND_READ, 7'd0, 1'b0, 2'(s % 4), reg_sel_t'(s), '0));
        send_item(mk_item(KIND_READ,  7'd0,   1'b0, 2'd1, REG_COP_EN_CLR, '0));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd1, REG_FIR_CLR,    32'hFFFF_FFFF));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd0, REG_CPU_EN_CLR, 32'hFFFF_FFFF));
        send_item(mk_item(KIND_WRITE, 7'd0,   1'b0, 2'd3, REG_COP_EN_CLR, 32'hFFFF_FFFF));
        send_item(mk_item(KIND_LINE,  7'd127, 1'b0, 2'd0, REG_CPU_IRQ_ACT, '0));

        // Random phases: no idling, sender idle, receiver stall, both
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(rand_item());
        end
        in_valid <= 1'b0;

        // Drain outstanding results
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("banked_irq_fiq_interrupt_controller_top regression: pass");
        else
            $display("banked_irq_fiq_interrupt_controller_top regression: fail");
        $finish;
    end

endmodule
